FILE: rtl/core/pkst_pkg.sv
// pkst_pkg: shared types and constants of the port knock sequence tracker
// no dependencies; used by pkst_ctrl, pkst_dp and port_knock_sequence_tracker

package pkst_pkg;

	localparam int ADDR_W     = 32;
	localparam int PORT_W     = 16;
	localparam int STAMP_W    = 32;
	localparam int WIN_W      = 8;
	localparam int TMO_W      = 16;
	localparam int OP_W       = 3;
	localparam int STAGE_W    = 2;
	localparam int CNT_W      = 7;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	// opcodes
	localparam logic [OP_W-1:0] OP_KNOCK  = 3'd0;
	localparam logic [OP_W-1:0] OP_QUERY  = 3'd1;
	localparam logic [OP_W-1:0] OP_REMOVE = 3'd2;
	localparam logic [OP_W-1:0] OP_FLUSH  = 3'd3;
	localparam logic [OP_W-1:0] OP_TICK   = 3'd4;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_FIRST_PORT     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SECOND_PORT    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_THIRD_PORT     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_STEP_WINDOW    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_EXPIRY_TIMEOUT = 3'd4;

	// configuration reset values
	localparam logic [PORT_W-1:0] RST_FIRST_PORT     = 16'd7000;
	localparam logic [PORT_W-1:0] RST_SECOND_PORT    = 16'd8000;
	localparam logic [PORT_W-1:0] RST_THIRD_PORT     = 16'd9000;
	localparam logic [WIN_W-1:0]  RST_STEP_WINDOW    = 8'd5;
	localparam logic [TMO_W-1:0]  RST_EXPIRY_TIMEOUT = 16'd30;

	// knock stages
	localparam logic [STAGE_W-1:0] STAGE_NONE   = 2'd0;
	localparam logic [STAGE_W-1:0] STAGE_FIRST  = 2'd1;
	localparam logic [STAGE_W-1:0] STAGE_SECOND = 2'd2;
	localparam logic [STAGE_W-1:0] STAGE_AUTH   = 2'd3;

	localparam logic [CNT_W-1:0] CNT_MAX = 7'd127;

	// one client table entry
	typedef struct packed {
		logic               valid;
		logic [STAGE_W-1:0] stage;
		logic [ADDR_W-1:0]  addr;
		logic [STAMP_W-1:0] stamp;
	} entry_t;

	// controller to datapath
	typedef struct packed {
		logic clear;    // write an empty entry at the sweep index
		logic idx_clr;  // restart the sweep index
		logic load;     // capture the input transfer
		logic scan;     // read the entry at the sweep index
		logic finish;   // apply the result and load the output register
	} pkst_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic idx_last; // sweep index sits on the last entry
		logic op_scan;  // offered opcode needs a table sweep
	} pkst_sts_t;

endpackage

FILE: rtl/core/pkst_ctrl.sv
// pkst_ctrl: sequencing state machine of the port knock sequence tracker
// depends on pkst_pkg; drives pkst_dp through pkst_cmd_t

module pkst_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	input  pkst_pkg::pkst_sts_t sts,
	output pkst_pkg::pkst_cmd_t cmd
);

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_SCAN,
		S_DRAIN,
		S_FINISH
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   out_room;

	assign out_room  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd = '0;
		case (state_q)
			S_CLEAR: begin
				cmd.clear   = 1'b1;
				cmd.idx_clr = sts.idx_last;
			end
			S_IDLE: begin
				cmd.load    = in_valid;
				cmd.idx_clr = in_valid;
			end
			S_SCAN: begin
				cmd.scan = 1'b1;
			end
			S_DRAIN: begin
				cmd = '0;
			end
			S_FINISH: begin
				cmd.finish = out_room;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_CLEAR: begin
					if (sts.idx_last) state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (in_valid) state_q <= sts.op_scan ? S_SCAN : S_FINISH;
				end
				S_SCAN: begin
					if (sts.idx_last) state_q <= S_DRAIN;
				end
				S_DRAIN: begin
					state_q <= S_FINISH;
				end
				S_FINISH: begin
					if (out_room) state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

FILE: rtl/core/pkst_dp.sv
// pkst_dp: client table memory, sweep logic, knock decision and result register
// depends on pkst_pkg; sequenced by pkst_ctrl

module pkst_dp #(
	parameter int TABLE_ENTRIES = 64
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_write_en,
	input  logic [pkst_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [pkst_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic [pkst_pkg::OP_W-1:0]           opcode,
	input  logic [pkst_pkg::ADDR_W-1:0]         client_address,
	input  logic [pkst_pkg::PORT_W-1:0]         port_number,
	input  pkst_pkg::pkst_cmd_t                 cmd,
	output pkst_pkg::pkst_sts_t                 sts,
	output logic                                accepted,
	output logic [pkst_pkg::STAGE_W-1:0]        stage_now,
	output logic                                table_full,
	output logic [pkst_pkg::CNT_W-1:0]          expired_count
);

	localparam int IDX_W = $clog2(TABLE_ENTRIES);
	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(TABLE_ENTRIES - 1);

	// configuration and time
	logic [pkst_pkg::PORT_W-1:0]  first_port_q, second_port_q, third_port_q;
	logic [pkst_pkg::WIN_W-1:0]   step_window_q;
	logic [pkst_pkg::TMO_W-1:0]   expiry_timeout_q;
	logic [pkst_pkg::STAMP_W-1:0] seconds_q;

	// captured item
	logic [pkst_pkg::OP_W-1:0]   op_q;
	logic [pkst_pkg::ADDR_W-1:0] addr_q;
	logic [pkst_pkg::PORT_W-1:0] port_q;

	// sweep
	logic [IDX_W-1:0]  idx_q;
	logic              chk_s1;
	logic [IDX_W-1:0]  idx_s1;
	pkst_pkg::entry_t  rd_s1;
	pkst_pkg::entry_t  mem [TABLE_ENTRIES];

	// lookup results
	logic                          found_q, free_q;
	logic [IDX_W-1:0]              k_q, f_q;
	logic [pkst_pkg::STAGE_W-1:0]  kstage_q;
	logic [pkst_pkg::STAMP_W-1:0]  kstamp_q;
	logic [pkst_pkg::CNT_W-1:0]    flush_cnt_q;

	// result register
	logic                          accepted_q, table_full_q;
	logic [pkst_pkg::STAGE_W-1:0]  stage_now_q;
	logic [pkst_pkg::CNT_W-1:0]    expired_count_q;

	logic                          hit, hole, stale;
	logic [pkst_pkg::STAMP_W-1:0]  rd_age, k_age;
	logic                          is_first, is_second, is_third, advance;
	logic [pkst_pkg::STAGE_W-1:0]  need;
	logic                          fin_we;
	logic [IDX_W-1:0]              fin_idx;
	pkst_pkg::entry_t              fin_entry;
	logic                          res_acc, res_full;
	logic [pkst_pkg::STAGE_W-1:0]  res_stage;
	logic                          mem_we;
	logic [IDX_W-1:0]              mem_waddr;
	pkst_pkg::entry_t              mem_wdata;

	assign sts.idx_last = (idx_q == IDX_LAST);
	assign sts.op_scan  = (opcode == pkst_pkg::OP_KNOCK) || (opcode == pkst_pkg::OP_QUERY) ||
		(opcode == pkst_pkg::OP_REMOVE) || (opcode == pkst_pkg::OP_FLUSH);

	// per-entry checks on the registered read
	assign hit    = chk_s1 && rd_s1.valid && (rd_s1.addr == addr_q);
	assign hole   = chk_s1 && !rd_s1.valid;
	assign rd_age = seconds_q - rd_s1.stamp;
	assign stale  = chk_s1 && (op_q == pkst_pkg::OP_FLUSH) && rd_s1.valid &&
		(rd_age > pkst_pkg::STAMP_W'(expiry_timeout_q));

	// knock decision
	assign k_age     = seconds_q - kstamp_q;
	assign is_first  = (port_q == first_port_q);
	assign is_second = (port_q == second_port_q);
	assign is_third  = (port_q == third_port_q);

	always_comb begin
		if (is_second) begin
			need = pkst_pkg::STAGE_FIRST;
		end else if (is_third) begin
			need = pkst_pkg::STAGE_SECOND;
		end else begin
			need = pkst_pkg::STAGE_NONE;
		end
	end

	assign advance = found_q && (need != pkst_pkg::STAGE_NONE) && (kstage_q == need) &&
		(k_age < pkst_pkg::STAMP_W'(step_window_q));

	always_comb begin
		fin_we    = 1'b0;
		fin_idx   = k_q;
		fin_entry = '{valid: 1'b1, stage: pkst_pkg::STAGE_FIRST, addr: addr_q,
			stamp: seconds_q};
		res_acc   = 1'b0;
		res_stage = pkst_pkg::STAGE_NONE;
		res_full  = 1'b0;
		case (op_q)
			pkst_pkg::OP_KNOCK: begin
				if (is_first) begin
					// start or restart, reusing the client's entry when there is one
					if (found_q || free_q) begin
						fin_we    = 1'b1;
						fin_idx   = found_q ? k_q : f_q;
						res_acc   = 1'b1;
						res_stage = pkst_pkg::STAGE_FIRST;
					end else begin
						res_full = 1'b1;
					end
				end else if (advance) begin
					fin_we          = 1'b1;
					fin_entry.stage = need + pkst_pkg::STAGE_W'(1);
					res_acc         = 1'b1;
					res_stage       = need + pkst_pkg::STAGE_W'(1);
				end else if (found_q) begin
					// wrong knock drops the client
					fin_we          = 1'b1;
					fin_entry.valid = 1'b0;
				end
			end
			pkst_pkg::OP_QUERY: begin
				res_stage = found_q ? kstage_q : pkst_pkg::STAGE_NONE;
			end
			pkst_pkg::OP_REMOVE: begin
				fin_we          = found_q;
				fin_entry.valid = 1'b0;
			end
			default: begin
				fin_we = 1'b0;
			end
		endcase
	end

	// single write port: clearing pass, flush invalidation, or final update
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = idx_q;
		mem_wdata = '0;
		if (cmd.clear) begin
			mem_we = 1'b1;
		end else if (stale) begin
			mem_we          = 1'b1;
			mem_waddr       = idx_s1;
			mem_wdata       = rd_s1;
			mem_wdata.valid = 1'b0;
		end else if (cmd.finish && fin_we) begin
			mem_we    = 1'b1;
			mem_waddr = fin_idx;
			mem_wdata = fin_entry;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_waddr] <= mem_wdata;
		if (cmd.scan) begin
			rd_s1  <= mem[idx_q];
			idx_s1 <= idx_q;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q   <= opcode;
			addr_q <= client_address;
			port_q <= port_number;
		end
		if (hit && !found_q) begin
			k_q      <= idx_s1;
			kstage_q <= rd_s1.stage;
			kstamp_q <= rd_s1.stamp;
		end
		if (hole && !free_q) f_q <= idx_s1;
		if (cmd.finish) begin
			accepted_q      <= res_acc;
			stage_now_q     <= res_stage;
			table_full_q    <= res_full;
			expired_count_q <= flush_cnt_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_port_q     <= pkst_pkg::RST_FIRST_PORT;
			second_port_q    <= pkst_pkg::RST_SECOND_PORT;
			third_port_q     <= pkst_pkg::RST_THIRD_PORT;
			step_window_q    <= pkst_pkg::RST_STEP_WINDOW;
			expiry_timeout_q <= pkst_pkg::RST_EXPIRY_TIMEOUT;
			seconds_q        <= '0;
			idx_q            <= '0;
			chk_s1           <= 1'b0;
			found_q          <= 1'b0;
			free_q           <= 1'b0;
			flush_cnt_q      <= '0;
		end else begin
			if (cfg_write_en) begin
				case (cfg_index)
					pkst_pkg::CFG_FIRST_PORT:     first_port_q     <= cfg_data;
					pkst_pkg::CFG_SECOND_PORT:    second_port_q    <= cfg_data;
					pkst_pkg::CFG_THIRD_PORT:     third_port_q     <= cfg_data;
					pkst_pkg::CFG_STEP_WINDOW:    step_window_q    <= cfg_data[pkst_pkg::WIN_W-1:0];
					pkst_pkg::CFG_EXPIRY_TIMEOUT: expiry_timeout_q <= cfg_data;
					default: ;
				endcase
			end
			if (cmd.finish && (op_q == pkst_pkg::OP_TICK)) seconds_q <= seconds_q + 1'b1;
			if (cmd.idx_clr) begin
				idx_q <= '0;
			end else if (cmd.clear || cmd.scan) begin
				idx_q <= idx_q + 1'b1;
			end
			chk_s1 <= cmd.scan;
			if (cmd.load) begin
				found_q     <= 1'b0;
				free_q      <= 1'b0;
				flush_cnt_q <= '0;
			end else begin
				if (hit) found_q <= 1'b1;
				if (hole) free_q <= 1'b1;
				if (stale && (flush_cnt_q != pkst_pkg::CNT_MAX)) flush_cnt_q <= flush_cnt_q + 1'b1;
			end
		end
	end

	assign accepted      = accepted_q;
	assign stage_now     = stage_now_q;
	assign table_full    = table_full_q;
	assign expired_count = expired_count_q;

endmodule

FILE: rtl/core/port_knock_sequence_tracker.sv
// port_knock_sequence_tracker: top level of the three-step port knock tracker
// depends on pkst_pkg, pkst_ctrl and pkst_dp
//
// channel   handshake               payload
// -------   ---------------------   ---------------------------------------------------
// input     in_valid / in_ready     opcode, client_address, port_number
// output    out_valid / out_ready   accepted, stage_now, table_full, expired_count
// config    cfg_write_en            cfg_index, cfg_data (no wait, no read-back)
//
// knock, query, remove and flush sweep the whole client table: it is one memory with a single
// write port, swept one entry per cycle, then a drain state settles the last read and a finish
// state writes the entry and loads the result; tick and unused opcodes go straight to finish
// after reset a clearing pass empties the table; in_ready stays low
// a finished result waits in the output register; the next transfer is still taken and
// swept, only its final update holds until the output register is free

module port_knock_sequence_tracker #(
	parameter int TABLE_ENTRIES = 64
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// configuration writes
	input  logic                            cfg_write_en,
	input  logic [pkst_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [pkst_pkg::CFG_DATA_W-1:0] cfg_data,
	// input items
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [pkst_pkg::OP_W-1:0]       opcode,
	input  logic [pkst_pkg::ADDR_W-1:0]     client_address,
	input  logic [pkst_pkg::PORT_W-1:0]     port_number,
	// result items
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic                            accepted,
	output logic [pkst_pkg::STAGE_W-1:0]    stage_now,
	output logic                            table_full,
	output logic [pkst_pkg::CNT_W-1:0]      expired_count
);

	// command and status between sequencer and datapath
	pkst_pkg::pkst_cmd_t cmd;
	pkst_pkg::pkst_sts_t sts;

	// sequencer: clearing pass, table sweep, final update and output handshake
	pkst_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// datapath: configuration, second counter, client table and result register
	pkst_dp #(
		.TABLE_ENTRIES (TABLE_ENTRIES)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_write_en   (cfg_write_en),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.opcode         (opcode),
		.client_address (client_address),
		.port_number    (port_number),
		.cmd            (cmd),
		.sts            (sts),
		.accepted       (accepted),
		.stage_now      (stage_now),
		.table_full     (table_full),
		.expired_count  (expired_count)
	);

endmodule

FILE: test/port_knock_sequence_tracker_tb.sv
// port_knock_sequence_tracker_tb: self-checking testbench for the three-step port knock tracker
// depends on pkst_pkg and port_knock_sequence_tracker; drives directed and random traffic and checks
// every result against an internal client-table predictor
`timescale 1ns / 100ps

module port_knock_sequence_tracker_tb;

	localparam int SLOTS           = 64;   // client table depth of the instance
	localparam int POOL_SIZE       = 10;   // recurring clients, small enough to never fill the table
	localparam int HOLD_OFF_CYCLES = 400;  // long receiver hold-off that backs up the block
	// quiet-cycle limit: hold-off, plus longest sender gap, receiver stall, clearing pass
	// and one table sweep, taken about three times over
	localparam int WATCHDOG_LIMIT  = 2000;

	typedef logic [pkst_pkg::ADDR_W-1:0]     addr_t;
	typedef logic [pkst_pkg::PORT_W-1:0]     port_t;
	typedef logic [pkst_pkg::OP_W-1:0]       op_t;
	typedef logic [pkst_pkg::STAGE_W-1:0]    stage_t;
	typedef logic [pkst_pkg::CNT_W-1:0]      cnt_t;
	typedef logic [pkst_pkg::STAMP_W-1:0]    stamp_t;
	typedef logic [pkst_pkg::WIN_W-1:0]      win_t;
	typedef logic [pkst_pkg::TMO_W-1:0]      tmo_t;
	typedef logic [pkst_pkg::CFG_IDX_W-1:0]  cfg_idx_t;
	typedef logic [pkst_pkg::CFG_DATA_W-1:0] cfg_data_t;

	// result of one transfer as the block reports it
	typedef struct packed {
		logic   accepted;
		stage_t stage;
		logic   full;
		cnt_t   expired;
	} verdict_t;

	// client table predictor and queue of verdicts still owed by the block
	class knock_scoreboard;
		port_t    first_port, second_port, third_port;
		win_t     step_window;
		tmo_t     expiry_timeout;
		bit       slot_used [SLOTS];
		addr_t    slot_addr [SLOTS];
		stage_t   slot_stage [SLOTS];
		stamp_t   slot_stamp [SLOTS];
		stamp_t   clock_sec;
		verdict_t verdicts_due [$];
		int       faults;

		function new();
			first_port     = pkst_pkg::RST_FIRST_PORT;
			second_port    = pkst_pkg::RST_SECOND_PORT;
			third_port     = pkst_pkg::RST_THIRD_PORT;
			step_window    = pkst_pkg::RST_STEP_WINDOW;
			expiry_timeout = pkst_pkg::RST_EXPIRY_TIMEOUT;
			clock_sec      = '0;
			faults         = 0;
			foreach (slot_used[i]) slot_used[i] = 1'b0;
		endfunction

		function void set_reg(cfg_idx_t idx, cfg_data_t value);
			case (idx)
				pkst_pkg::CFG_FIRST_PORT:     first_port     = value;
				pkst_pkg::CFG_SECOND_PORT:    second_port    = value;
				pkst_pkg::CFG_THIRD_PORT:     third_port     = value;
				pkst_pkg::CFG_STEP_WINDOW:    step_window    = value[pkst_pkg::WIN_W-1:0];
				pkst_pkg::CFG_EXPIRY_TIMEOUT: expiry_timeout = value;
				default: ;
			endcase
		endfunction

		function int find_client(addr_t addr);
			for (int i = 0; i < SLOTS; i++)
				if (slot_used[i] && slot_addr[i] == addr) return i;
			return -1;
		endfunction

		function int find_free();
			for (int i = 0; i < SLOTS; i++)
				if (!slot_used[i]) return i;
			return -1;
		endfunction

		// advances the table for one transfer and returns the verdict it earns
		function verdict_t knock_outcome(op_t op, addr_t addr, port_t port);
			verdict_t v;
			int       k;
			stage_t   need;
			stamp_t   elapsed;
			v = '0;
			case (op)
				pkst_pkg::OP_KNOCK: begin
					k = find_client(addr);
					if (port == first_port) begin
						if (k < 0) k = find_free();
						if (k < 0) begin
							v.full = 1'b1;
						end else begin
							slot_used[k]  = 1'b1;
							slot_addr[k]  = addr;
							slot_stage[k] = pkst_pkg::STAGE_FIRST;
							slot_stamp[k] = clock_sec;
							v.accepted    = 1'b1;
							v.stage       = pkst_pkg::STAGE_FIRST;
						end
					end else begin
						need = pkst_pkg::STAGE_NONE;
						if (port == second_port) need = pkst_pkg::STAGE_FIRST;
						else if (port == third_port) need = pkst_pkg::STAGE_SECOND;
						elapsed = (k >= 0) ? clock_sec - slot_stamp[k] : '0;
						if (k >= 0 && need != pkst_pkg::STAGE_NONE && slot_stage[k] == need &&
								elapsed < stamp_t'(step_window)) begin
							slot_stage[k] = need + stage_t'(1);
							slot_stamp[k] = clock_sec;
							v.accepted    = 1'b1;
							v.stage       = need + stage_t'(1);
						end else if (k >= 0) begin
							slot_used[k] = 1'b0;
						end
					end
				end
				pkst_pkg::OP_QUERY: begin
					k = find_client(addr);
					if (k >= 0) v.stage = slot_stage[k];
				end
				pkst_pkg::OP_REMOVE: begin
					k = find_client(addr);
					if (k >= 0) slot_used[k] = 1'b0;
				end
				pkst_pkg::OP_FLUSH: begin
					for (int i = 0; i < SLOTS; i++) begin
						elapsed = clock_sec - slot_stamp[i];
						if (slot_used[i] && elapsed > stamp_t'(expiry_timeout)) begin
							slot_used[i] = 1'b0;
							if (v.expired != pkst_pkg::CNT_MAX) v.expired = v.expired + cnt_t'(1);
						end
					end
				end
				pkst_pkg::OP_TICK: clock_sec = clock_sec + stamp_t'(1);
				default: ;
			endcase
			return v;
		endfunction

		function void take_request(op_t op, addr_t addr, port_t port);
			verdicts_due.push_back(knock_outcome(op, addr, port));
		endfunction

		function void check_reply(verdict_t got);
			verdict_t want;
			if (verdicts_due.size() == 0) begin
				faults++;
				if (faults <= 10)
					$display("%0t: result with nothing expected: acc=%0d stage=%0d full=%0d exp=%0d",
						$realtime, got.accepted, got.stage, got.full, got.expired);
				return;
			end
			want = verdicts_due.pop_front();
			if (got.accepted !== want.accepted || got.stage !== want.stage ||
					got.full !== want.full || got.expired !== want.expired) begin
				faults++;
				if (faults <= 10)
					$display("%0t: mismatch: expected acc=%0d stage=%0d full=%0d exp=%0d, got acc=%0d stage=%0d full=%0d exp=%0d",
						$realtime, want.accepted, want.stage, want.full, want.expired,
						got.accepted, got.stage, got.full, got.expired);
			end
		endfunction

		function int outstanding();
			return verdicts_due.size();
		endfunction
	endclass

	logic      clk = 1'b0;
	logic      arst_n;
	logic      cfg_write_en;
	cfg_idx_t  cfg_index;
	cfg_data_t cfg_data;
	logic      in_valid;
	logic      in_ready;
	op_t       opcode;
	addr_t     client_address;
	port_t     port_number;
	logic      out_valid;
	logic      out_ready;
	logic      accepted;
	stage_t    stage_now;
	logic      table_full;
	cnt_t      expired_count;

	knock_scoreboard sb;
	addr_t           pool [POOL_SIZE];
	int              requests_sent = 0;
	int              calm_left     = 0;   // sender transfers left with no gap
	int              quiet_cycles  = 0;
	bit              hold_off_req  = 1'b0;

	port_knock_sequence_tracker #(
		.TABLE_ENTRIES(SLOTS)
	) uut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_write_en   (cfg_write_en),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.opcode         (opcode),
		.client_address (client_address),
		.port_number    (port_number),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.accepted       (accepted),
		.stage_now      (stage_now),
		.table_full     (table_full),
		.expired_count  (expired_count)
	);

	// 4 ns clock
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// every result transfer is checked against the oldest pending verdict
	always @(posedge clk) begin : result_monitor
		verdict_t got;
		if (arst_n && out_valid && out_ready) begin
			got.accepted = accepted;
			got.stage    = stage_now;
			got.full     = table_full;
			got.expired  = expired_count;
			sb.check_reply(got);
		end
	end

	// watchdog: too long without any transfer on either channel ends the run
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("port_knock_sequence_tracker test failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// result receiver: mostly ready, short and long stalls, calm stretches,
	// and one long hold-off on request so the block backs up into its input
	initial begin : result_sink
		int          stall;
		int          free_run;
		int unsigned r;
		stall    = 0;
		free_run = 0;
		out_ready <= 1'b0;
		forever begin
			@(negedge clk);
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				stall        = HOLD_OFF_CYCLES;
				free_run     = 0;
			end
			if (stall > 0) begin
				stall--;
				out_ready <= 1'b0;
			end else if (free_run > 0) begin
				free_run--;
				out_ready <= 1'b1;
			end else begin
				r = $urandom_range(0, 99);
				if (r < 3) begin
					free_run = $urandom_range(80, 200);
					out_ready <= 1'b1;
				end else if (r < 60) begin
					out_ready <= 1'b1;
				end else if (r < 95) begin
					stall = $urandom_range(0, 3);
					out_ready <= 1'b0;
				end else begin
					stall = $urandom_range(10, 60);
					out_ready <= 1'b0;
				end
			end
		end
	end

	// offers one request after a random gap and returns at the edge of its transfer
	task automatic send_item(input op_t op, input addr_t addr, input port_t port);
		int          gap;
		int unsigned r;
		gap = 0;
		if (calm_left > 0) begin
			calm_left--;
		end else begin
			r = $urandom_range(0, 99);
			if (r < 3) calm_left = $urandom_range(30, 60);
			else if (r < 50) gap = 0;
			else if (r < 92) gap = $urandom_range(1, 3);
			else gap = $urandom_range(8, 40);
		end
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid       <= 1'b1;
		opcode         <= op;
		client_address <= addr;
		port_number    <= port;
		do @(posedge clk); while (!in_ready);
		sb.take_request(op, addr, port);
		requests_sent++;
	endtask

	// drop valid and wait until every owed result has come back
	task automatic settle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (sb.outstanding() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_idx_t idx, input cfg_data_t value);
		@(negedge clk);
		cfg_write_en <= 1'b1;
		cfg_index    <= idx;
		cfg_data     <= value;
		@(negedge clk);
		cfg_write_en <= 1'b0;
		sb.set_reg(idx, value);
	endtask

	// registers change only with the block idle
	task automatic change_settings(input port_t first, input port_t second, input port_t third,
			input win_t window, input tmo_t expiry);
		settle();
		write_reg(pkst_pkg::CFG_FIRST_PORT, first);
		write_reg(pkst_pkg::CFG_SECOND_PORT, second);
		write_reg(pkst_pkg::CFG_THIRD_PORT, third);
		write_reg(pkst_pkg::CFG_STEP_WINDOW, cfg_data_t'(window));
		write_reg(pkst_pkg::CFG_EXPIRY_TIMEOUT, expiry);
	endtask

	// mostly full knock sequences by recurring clients with random tick gaps,
	// some wrong ports and aborted sequences, plus queries, removals, flushes and noise
	task automatic run_random(input int count);
		int unsigned r;
		int unsigned reach;
		int          target;
		addr_t       who;
		port_t       door;
		op_t         code;
		target = requests_sent + count;
		while (requests_sent < target) begin
			r   = $urandom_range(0, 99);
			who = pool[$urandom_range(0, POOL_SIZE - 1)];
			if (r < 55) begin
				send_item(pkst_pkg::OP_KNOCK, who, sb.first_port);
				for (int step = 0; step < 2; step++) begin
					// tick counts straddle the step window where it is small
					reach = (sb.step_window > 6) ? 7 : sb.step_window + 1;
					repeat ($urandom_range(0, reach))
						send_item(pkst_pkg::OP_TICK, $urandom, port_t'($urandom));
					door = (step == 0) ? sb.second_port : sb.third_port;
					if ($urandom_range(0, 9) == 0) door = port_t'($urandom);
					send_item(pkst_pkg::OP_KNOCK, who, door);
					if ($urandom_range(0, 9) == 0) break;
				end
				if ($urandom_range(0, 1) == 1)
					send_item(pkst_pkg::OP_QUERY, who, port_t'($urandom));
			end else if (r < 65) begin
				send_item(pkst_pkg::OP_QUERY, who, port_t'($urandom));
			end else if (r < 72) begin
				send_item(pkst_pkg::OP_REMOVE, who, port_t'($urandom));
			end else if (r < 80) begin
				repeat ($urandom_range(0, 4))
					send_item(pkst_pkg::OP_TICK, $urandom, port_t'($urandom));
				send_item(pkst_pkg::OP_FLUSH, $urandom, port_t'($urandom));
			end else if (r < 88) begin
				if ($urandom_range(0, 9) == 0)
					repeat ($urandom_range(10, 40))
						send_item(pkst_pkg::OP_TICK, $urandom, port_t'($urandom));
				else
					repeat ($urandom_range(1, 3))
						send_item(pkst_pkg::OP_TICK, $urandom, port_t'($urandom));
			end else begin
				// noise: any opcode, any address, configured or random port
				code = op_t'($urandom);
				case ($urandom_range(0, 3))
					0: door = sb.first_port;
					1: door = sb.second_port;
					2: door = sb.third_port;
					default: door = port_t'($urandom);
				endcase
				send_item(code, ($urandom_range(0, 1) == 1) ? who : addr_t'($urandom), door);
			end
		end
	endtask

	initial begin : stimulus
		addr_t cli_a, cli_b, cli_c;
		op_t   spare;
		sb = new();
		arst_n         <= 1'b0;
		in_valid       <= 1'b0;
		opcode         <= pkst_pkg::OP_KNOCK;
		client_address <= '0;
		port_number    <= '0;
		cfg_write_en   <= 1'b0;
		cfg_index      <= pkst_pkg::CFG_FIRST_PORT;
		cfg_data       <= '0;
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;

		pool[0] = '0;
		pool[1] = '1;
		for (int i = 2; i < POOL_SIZE; i++) pool[i] = $urandom;
		cli_a = 32'h0a00_0001;
		cli_b = '1;
		cli_c = '0;

		// directed part under reset settings
		send_item(pkst_pkg::OP_QUERY, cli_a, '0);                   // unknown client reads stage 0
		send_item(pkst_pkg::OP_KNOCK, cli_a, pkst_pkg::RST_FIRST_PORT);  // full sequence
		send_item(pkst_pkg::OP_KNOCK, cli_a, pkst_pkg::RST_SECOND_PORT);
		send_item(pkst_pkg::OP_KNOCK, cli_a, pkst_pkg::RST_THIRD_PORT);
		send_item(pkst_pkg::OP_QUERY, cli_a, '1);
		send_item(pkst_pkg::OP_KNOCK, cli_b, pkst_pkg::RST_FIRST_PORT);
		repeat (5) send_item(pkst_pkg::OP_TICK, $urandom, port_t'($urandom));
		// exactly at the window: refused, erased
		send_item(pkst_pkg::OP_KNOCK, cli_b, pkst_pkg::RST_SECOND_PORT);
		send_item(pkst_pkg::OP_QUERY, cli_b, '0);
		send_item(pkst_pkg::OP_KNOCK, cli_c, '0);                   // stray port with no entry
		send_item(pkst_pkg::OP_KNOCK, cli_c, pkst_pkg::RST_FIRST_PORT);
		send_item(pkst_pkg::OP_KNOCK, cli_c, '1);                   // stray port erases the entry
		send_item(pkst_pkg::OP_KNOCK, cli_c, pkst_pkg::RST_FIRST_PORT);
		send_item(pkst_pkg::OP_KNOCK, cli_c, pkst_pkg::RST_THIRD_PORT);  // out of order
		send_item(pkst_pkg::OP_KNOCK, cli_c, pkst_pkg::RST_FIRST_PORT);
		send_item(pkst_pkg::OP_KNOCK, cli_c, pkst_pkg::RST_FIRST_PORT);  // restart keeps stage 1
		send_item(pkst_pkg::OP_REMOVE, cli_c, '0);
		send_item(pkst_pkg::OP_QUERY, cli_c, '0);
		for (int i = 5; i < 8; i++) begin
			spare = op_t'(i);
			send_item(spare, $urandom, port_t'($urandom));          // unused opcodes
		end
		send_item(pkst_pkg::OP_FLUSH, '0, '0);
		send_item(pkst_pkg::OP_REMOVE, cli_a, '0);
		run_random(60);

		// extreme ports, window of one, flush removes anything older than now
		change_settings(16'd0, 16'hffff, 16'd1234, 8'd1, 16'd0);
		run_random(40);
		// flood with new clients until the table refuses them
		repeat (70) send_item(pkst_pkg::OP_KNOCK, $urandom, sb.first_port);
		send_item(pkst_pkg::OP_KNOCK, 32'h7f00_0001, sb.first_port);
		send_item(pkst_pkg::OP_TICK, '1, '1);
		send_item(pkst_pkg::OP_FLUSH, '0, '0);
		run_random(30);

		// first and second port equal, widest window, flush never expires;
		// the receiver holds off for a long stretch while requests keep coming
		change_settings(16'hffff, 16'hffff, 16'd0, 8'd255, 16'hffff);
		hold_off_req = 1'b1;
		run_random(80);

		// second and third port equal, zero window: no advance can succeed
		change_settings(16'd100, 16'd200, 16'd200, 8'd0, 16'd3);
		run_random(70);

		change_settings(port_t'($urandom), port_t'($urandom), port_t'($urandom),
			win_t'($urandom_range(2, 8)), tmo_t'($urandom_range(0, 20)));
		run_random(80);

		settle();
		repeat (SLOTS + 8) @(posedge clk);
		if (sb.faults == 0 && sb.outstanding() == 0)
			$display("port_knock_sequence_tracker test passed");
		else
			$display("port_knock_sequence_tracker test failed");
		$finish;
	end

endmodule

FILE: sim.f
rtl/core/pkst_pkg.sv
rtl/core/pkst_ctrl.sv
rtl/core/pkst_dp.sv
rtl/core/port_knock_sequence_tracker.sv
test/port_knock_sequence_tracker_tb.sv
